[src/free_list_fit_search_assert.svh]
// Assertion helpers for the free list fit search block
`ifndef FREE_LIST_FIT_SEARCH_ASSERT_SVH
`define FREE_LIST_FIT_SEARCH_ASSERT_SVH

// same-cycle implication
`define FLFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FLFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/flfs_pkg.sv]
package flfs_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W     = 32;
  localparam int ID_W       = 8;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] mode_t;

  localparam action_t ACT_CLEAR  = 2'd0;
  localparam action_t ACT_APPEND = 2'd1;
  localparam action_t ACT_SEARCH = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_NOFIT = 2'd2;

  localparam mode_t FIT_FIRST = 2'd0;
  localparam mode_t FIT_BEST  = 2'd1;
  localparam mode_t FIT_WORST = 2'd2;

  localparam logic REG_FIT_MODE = 1'b0;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } ent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    ent_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[src/flfs_if.sv]
interface flfs_in_if;
  import flfs_pkg::*;
  logic                valid;
  logic                ready;
  action_t             action;
  logic [SIZE_W-1:0]   entry_size;
  logic [ID_W-1:0]     entry_id;
  logic [SIZE_W-1:0]   request_size;

  modport source (output valid, action, entry_size, entry_id, request_size, input ready);
  modport sink (input valid, action, entry_size, entry_id, request_size, output ready);
endinterface

interface flfs_out_if;
  import flfs_pkg::*;
  logic            valid;
  logic            ready;
  status_t         status;
  logic            found;
  logic [ID_W-1:0] block_id;

  modport source (output valid, status, found, block_id, input ready);
  modport sink (input valid, status, found, block_id, output ready);
endinterface

[src/free_list_fit_search.sv]
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | action, entry_size, entry_id, request_size
// out_ch   | out | valid/ready        | status, found, block_id
// cfg_*    | in  | APB, pready high   | fit_mode at byte address 0
//
// Clear and append: result registered at the accepting edge.
// Search: one entry per cycle through the single read port of the table memory
// (registered read); first fit stops at the hit.
// Reset clears the entry count, FSM state, output valid and fit_mode; the table needs no clearing pass.
// A transaction is accepted when idle and the result register is empty or being taken.
`include "free_list_fit_search_assert.svh"

module free_list_fit_search (
  input  logic                        clk,
  input  logic                        rst_n,
  flfs_in_if.sink                     in_ch,
  flfs_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [flfs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [flfs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [flfs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import flfs_pkg::*;

  mode_t    fit_mode;
  mem_req_t mem_req;
  ent_t     rd_data;

  flfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .fit_mode (fit_mode)
  );

  flfs_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  flfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fit_mode (fit_mode),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  `FLFS_ASSERT_NXT(a_short_op_result, clk, rst_n,
    in_ch.valid && in_ch.ready && in_ch.action != ACT_SEARCH,
    out_ch.valid, "clear/append transaction gave no result")
  `FLFS_ASSERT_NXT(a_search_busy, clk, rst_n,
    in_ch.valid && in_ch.ready && in_ch.action == ACT_SEARCH &&
    (fit_mode == FIT_FIRST || fit_mode == FIT_BEST || fit_mode == FIT_WORST),
    !in_ch.ready, "accepted during search")
  `FLFS_ASSERT_NOW(a_found_ok, clk, rst_n, out_ch.valid && out_ch.found,
    out_ch.status == ST_OK, "found with bad status")
  `FLFS_ASSERT_NOW(a_id_zero, clk, rst_n, out_ch.valid && !out_ch.found,
    out_ch.block_id == '0, "block id set without a fit")

endmodule

[src/flfs_mem.sv]
module flfs_mem (
  input  logic              clk,
  input  flfs_pkg::mem_req_t req,
  output flfs_pkg::ent_t     rd_data
);
  import flfs_pkg::*;

  ent_t mem_r [MAX_BLOCKS];
  ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

[src/flfs_cfg.sv]
module flfs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [flfs_pkg::CFG_AW-1:0] paddr,
  input  logic [flfs_pkg::CFG_DW-1:0] pwdata,
  output logic [flfs_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output flfs_pkg::mode_t             fit_mode
);
  import flfs_pkg::*;

  mode_t fit_mode_r;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FIT_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
    end else if (wr_en) begin
      fit_mode_r <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FIT_MODE) begin
      prdata = {{(CFG_DW-2){1'b0}}, fit_mode_r};
    end
  end

  assign fit_mode = fit_mode_r;
endmodule

[src/flfs_ctrl.sv]
module flfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  flfs_pkg::mode_t     fit_mode,
  flfs_in_if.sink             in_ch,
  flfs_out_if.source          out_ch,
  output flfs_pkg::mem_req_t  mem_req,
  input  flfs_pkg::ent_t      rd_data
);
  import flfs_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              have_r, have_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  mode_t             mode_r, mode_nxt;
  logic              out_vld_r, out_vld_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;

  logic acc, full, rd_issue, fits, take;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_vld_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(MAX_BLOCKS));
  assign rd_issue    = (state_r == S_SCAN) && (rd_idx_r != cnt_r);
  assign fits        = (rd_data.size >= req_r);

  always_comb begin
    case (mode_r)
      FIT_BEST:  take = fits && (!have_r || rd_data.size < best_size_r);
      FIT_WORST: take = fits && (rd_data.size != '0) && (!have_r || rd_data.size > best_size_r);
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    mem_req.we    = acc && (in_ch.action == ACT_APPEND) && !full;
    mem_req.waddr = cnt_r[IDX_W-1:0];
    mem_req.wdata = '{size: in_ch.entry_size, id: in_ch.entry_id};
    mem_req.re    = rd_issue;
    mem_req.raddr = rd_idx_r[IDX_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = rd_issue;
    have_nxt       = have_r;
    best_size_nxt  = best_size_r;
    best_id_nxt    = best_id_r;
    req_nxt        = req_r;
    mode_nxt       = mode_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_id_nxt     = out_id_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_status_nxt = ST_OK;
          out_found_nxt  = 1'b0;
          out_id_nxt     = '0;
          case (in_ch.action)
            ACT_CLEAR: begin
              cnt_nxt     = '0;
              out_vld_nxt = 1'b1;
            end
            ACT_APPEND: begin
              out_vld_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_SEARCH: begin
              if (fit_mode != FIT_FIRST && fit_mode != FIT_BEST && fit_mode != FIT_WORST) begin
                out_vld_nxt    = 1'b1;
                out_status_nxt = ST_NOFIT;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = '0;
                have_nxt   = 1'b0;
                req_nxt    = in_ch.request_size;
                mode_nxt   = fit_mode;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (pend_r && take) begin
          have_nxt      = 1'b1;
          best_size_nxt = rd_data.size;
          best_id_nxt   = rd_data.id;
        end
        if (pend_r && mode_r == FIT_FIRST && fits) begin
          state_nxt      = S_IDLE;
          out_vld_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_found_nxt  = 1'b1;
          out_id_nxt     = rd_data.id;
        end else if (!pend_r && !rd_issue) begin
          state_nxt      = S_IDLE;
          out_vld_nxt    = 1'b1;
          out_status_nxt = have_r ? ST_OK : ST_NOFIT;
          out_found_nxt  = have_r;
          out_id_nxt     = have_r ? best_id_r : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rd_idx_r  <= '0;
      pend_r    <= 1'b0;
      have_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pend_r    <= pend_nxt;
      have_r    <= have_nxt;
      out_vld_r <= out_vld_nxt;
    end
    best_size_r  <= best_size_nxt;
    best_id_r    <= best_id_nxt;
    req_r        <= req_nxt;
    mode_r       <= mode_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.block_id = out_id_r;
endmodule

[sim/free_list_fit_search_test.sv]
`timescale 1ns / 1ps

module free_list_fit_search_test;
  import flfs_pkg::*;

  localparam mode_t   FIT_UNUSED = 2'd3;
  localparam action_t ACT_NOP    = 2'd3;
  localparam logic [CFG_AW-1:0] FIT_MODE_ADDR = CFG_AW'(4 * REG_FIT_MODE);
  localparam int PHASE_JOBS = 200;

  typedef struct packed {
    action_t           action;
    logic [SIZE_W-1:0] entry_size;
    logic [ID_W-1:0]   entry_id;
    logic [SIZE_W-1:0] request_size;
  } job_t;

  typedef struct packed {
    status_t         status;
    logic            found;
    logic [ID_W-1:0] block_id;
  } outcome_t;

  bit clk = 0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  flfs_in_if  in_ch ();
  flfs_out_if out_ch ();

  free_list_fit_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // free table mirror
  logic [SIZE_W-1:0] fit_sizes [MAX_BLOCKS];
  logic [ID_W-1:0]   fit_ids   [MAX_BLOCKS];
  int                fit_count;
  mode_t             fit_mode_copy;

  job_t     job_q [$];
  outcome_t outcome_q [$];
  int       jobs_queued;
  int       jobs_accepted;
  int       errors;
  bit       in_fire;
  bit       steady;
  job_t     drv_job;
  job_t     seen_job;
  outcome_t want;

  function automatic outcome_t predict_outcome(job_t j);
    outcome_t r;
    logic hit;
    logic [SIZE_W-1:0] best;
    logic [SIZE_W-1:0] s;
    int pick;
    r.status = ST_OK;
    r.found = 1'b0;
    r.block_id = '0;
    case (j.action)
      ACT_CLEAR: fit_count = 0;
      ACT_APPEND: begin
        if (fit_count >= MAX_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          fit_sizes[fit_count] = j.entry_size;
          fit_ids[fit_count] = j.entry_id;
          fit_count++;
        end
      end
      ACT_SEARCH: begin
        hit = 1'b0;
        best = '0;
        pick = 0;
        if (fit_mode_copy != FIT_UNUSED) begin
          for (int k = 0; k < fit_count; k++) begin
            s = fit_sizes[k];
            if (s >= j.request_size) begin
              if ((fit_mode_copy == FIT_FIRST && !hit) ||
                  (fit_mode_copy == FIT_BEST && (!hit || s < best)) ||
                  (fit_mode_copy == FIT_WORST && s != 0 && (!hit || s > best))) begin
                hit = 1'b1;
                best = s;
                pick = k;
              end
            end
          end
        end
        if (hit) begin
          r.found = 1'b1;
          r.block_id = fit_ids[pick];
        end else begin
          r.status = ST_NOFIT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic job_t mk_job(action_t a, logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id,
                                  logic [SIZE_W-1:0] req);
    job_t j;
    j.action = a;
    j.entry_size = sz;
    j.entry_id = id;
    j.request_size = req;
    return j;
  endfunction

  task automatic queue_job(job_t j);
    job_q.push_back(j);
    jobs_queued++;
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 22) return '1;
    if (r < 45) return $urandom;
    return $urandom_range(1, 24);
  endfunction

  function automatic logic [SIZE_W-1:0] rand_request(input logic [SIZE_W-1:0] pool [$]);
    int r;
    r = $urandom_range(99);
    if (pool.size() != 0 && r < 55)
      return pool[$urandom_range(pool.size() - 1)] + SIZE_W'($urandom_range(2)) - 1;
    if (r < 65) return '0;
    if (r < 72) return '1;
    if (r < 85) return $urandom_range(0, 25);
    return $urandom;
  endfunction

  // clear, fill with occasional searches, then a burst of searches; occasional stray transactions
  task automatic queue_episode();
    logic [SIZE_W-1:0] pool [$];
    logic [SIZE_W-1:0] sz;
    int n;
    int ns;
    queue_job(mk_job(ACT_CLEAR, $urandom, ID_W'($urandom), $urandom));
    n = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 12);
    for (int k = 0; k < n; k++) begin
      sz = rand_size();
      queue_job(mk_job(ACT_APPEND, sz, ID_W'($urandom), $urandom));
      pool.push_back(sz);
      if ($urandom_range(9) == 0)
        queue_job(mk_job(ACT_SEARCH, $urandom, ID_W'($urandom), rand_request(pool)));
    end
    ns = $urandom_range(2, 8);
    for (int k = 0; k < ns; k++) begin
      if ($urandom_range(19) == 0)
        queue_job(mk_job(action_t'($urandom_range(3)), $urandom, ID_W'($urandom),
                         $urandom));
      else
        queue_job(mk_job(ACT_SEARCH, $urandom, ID_W'($urandom), rand_request(pool)));
    end
  endtask

  task automatic cfg_write(mode_t m);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = FIT_MODE_ADDR;
    cfg_pwdata = CFG_DW'(m);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(negedge clk); while (!cfg_pready);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic drain();
    while (jobs_accepted != jobs_queued || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (job_q.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
        drv_job = job_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= drv_job.action;
        in_ch.entry_size <= drv_job.entry_size;
        in_ch.entry_id <= drv_job.entry_id;
        in_ch.request_size <= drv_job.request_size;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 14);
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == FIT_MODE_ADDR)
        fit_mode_copy = mode_t'(cfg_pwdata[1:0]);
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction status=%0d found=%0d block_id=%0d",
                   $time, out_ch.status, out_ch.found, out_ch.block_id);
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_ch.status);
          end
          if (out_ch.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d actual %0d", $time, want.found, out_ch.found);
          end
          if (out_ch.block_id !== want.block_id) begin
            errors++;
            $display("%0t: block_id expected %0d actual %0d", $time, want.block_id,
                     out_ch.block_id);
          end
        end
      end
      if (in_fire) begin
        seen_job.action = in_ch.action;
        seen_job.entry_size = in_ch.entry_size;
        seen_job.entry_id = in_ch.entry_id;
        seen_job.request_size = in_ch.request_size;
        outcome_q.push_back(predict_outcome(seen_job));
        jobs_accepted++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("free_list_fit_search regression: fail");
    $finish;
  end

  initial begin
    mode_t plan [8];
    plan = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_UNUSED, FIT_WORST, FIT_BEST, FIT_FIRST,
             FIT_WORST};
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CLEAR;
    in_ch.entry_size = '0;
    in_ch.entry_id = '0;
    in_ch.request_size = '0;
    out_ch.ready = 1'b0;
    fit_count = 0;
    fit_mode_copy = FIT_FIRST;
    errors = 0;
    jobs_queued = 0;
    jobs_accepted = 0;
    steady = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, first fit from reset
    queue_job(mk_job(ACT_CLEAR, '0, '0, '0));
    queue_job(mk_job(ACT_SEARCH, '0, '0, '0));
    queue_job(mk_job(ACT_APPEND, '0, 8'h00, '0));
    queue_job(mk_job(ACT_APPEND, '1, 8'hff, '0));
    queue_job(mk_job(ACT_APPEND, 32'd5, 8'h15, '0));
    queue_job(mk_job(ACT_APPEND, 32'd5, 8'h25, '0));
    queue_job(mk_job(ACT_APPEND, 32'd3, 8'h33, '0));
    queue_job(mk_job(ACT_SEARCH, '0, '0, '0));
    queue_job(mk_job(ACT_SEARCH, '0, '0, 32'd4));
    queue_job(mk_job(ACT_SEARCH, '0, '0, 32'd6));
    queue_job(mk_job(ACT_SEARCH, '0, '0, '1));
    queue_job(mk_job(ACT_NOP, '1, '1, '1));
    for (int k = 0; k < 11; k++)
      queue_job(mk_job(ACT_APPEND, 32'd100 + k, ID_W'(8'h40 + k), '0));
    queue_job(mk_job(ACT_APPEND, 32'd7, 8'h77, '0));
    queue_job(mk_job(ACT_SEARCH, '1, '1, 32'd105));
    drain();

    for (int p = 0; p < 8; p++) begin
      cfg_write(plan[p]);
      steady = (p == 4);
      while (jobs_queued < jobs_accepted + PHASE_JOBS) queue_episode();
      drain();
    end
    steady = 1'b0;
    repeat (40) @(posedge clk);

    if (errors == 0 && outcome_q.size() == 0)
      $display("free_list_fit_search regression: pass");
    else
      $display("free_list_fit_search regression: fail");
    $finish;
  end

endmodule
